// ===== hdl/esd_pkg.sv =====
// Shared types, codes and constants of the encoder speed and PWM motor drive.
`timescale 1ns / 1ps
package esd_pkg;

	// Field widths
	localparam int ACTION_W = 3;
	localparam int SPEED_W  = 16;
	localparam int CNT_W    = 32;

	// Action codes on the command channel
	localparam logic [ACTION_W-1:0] ACT_EDGE  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_SPEED = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_DIR   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd4;

	// Operation codes handed from the front to the back
	localparam logic [2:0] OP_NOP    = 3'd0;
	localparam logic [2:0] OP_CNT_UP = 3'd1;
	localparam logic [2:0] OP_CNT_DN = 3'd2;
	localparam logic [2:0] OP_TICK   = 3'd3;
	localparam logic [2:0] OP_SPEED  = 3'd4;
	localparam logic [2:0] OP_DIR    = 3'd5;
	localparam logic [2:0] OP_STOP   = 3'd6;

	// Bridge pin patterns, bit 0 is input A, bit 1 is input B
	localparam logic [1:0] PINS_OFF = 2'b00;
	localparam logic [1:0] PINS_CW  = 2'b01;
	localparam logic [1:0] PINS_CCW = 2'b10;

	localparam logic [SPEED_W-1:0] DUTY_FULL       = 16'hFFFF;
	localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = 16'hFFFF;
	localparam logic [SPEED_W-1:0] SCALE_RESET     = 16'd1;

	localparam int PPR_DEFAULT   = 20;
	localparam int QUEUE_DEFAULT = 4;

	// Window divide pipeline: quotient bits resolved per stage, and stage count
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = CNT_W / DIV_STEPS;

	typedef struct packed {
		logic [2:0]         op;
		logic [SPEED_W-1:0] speed;
		logic               dir;
	} esd_op_t;

endpackage

// ===== hdl/esd_channels.sv =====
// Handshake channel interfaces: command items, status items and the max speed write.
`timescale 1ns / 1ps
interface esd_cmd_if;
	import esd_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic                enc_b_level;
	logic [SPEED_W-1:0]  speed_cmd;
	logic                dir_cmd;
	modport source (output valid, action, enc_b_level, speed_cmd, dir_cmd, input ready);
	modport sink (input valid, action, enc_b_level, speed_cmd, dir_cmd, output ready);
endinterface

interface esd_status_if;
	import esd_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    bridge_a;
	logic                    bridge_b;
	logic [SPEED_W-1:0]      pwm_level;
	logic signed [CNT_W-1:0] measured_speed;
	logic [SPEED_W-1:0]      target_speed;
	modport source (output valid, bridge_a, bridge_b, pwm_level, measured_speed,
		target_speed, input ready);
	modport sink (input valid, bridge_a, bridge_b, pwm_level, measured_speed,
		target_speed, output ready);
endinterface

interface esd_cfg_if;
	import esd_pkg::*;
	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] max_speed;
	modport source (output valid, max_speed, input ready);
	modport sink (input valid, max_speed, output ready);
endinterface

// ===== hdl/esd_scale.sv =====
// Max speed register and the bit-serial divider that derives the PWM scale.
`timescale 1ns / 1ps
module esd_scale (
	input  logic                    clk,
	input  logic                    arst_n,
	esd_cfg_if.sink                 cfg,
	output logic [esd_pkg::SPEED_W-1:0] max_speed,
	output logic [esd_pkg::SPEED_W-1:0] duty_scale,
	output logic                    busy
);
	import esd_pkg::*;

	localparam int STEP_W = $clog2(SPEED_W + 1);

	logic [SPEED_W-1:0] max_q;
	logic [SPEED_W-1:0] scale_q;
	logic               busy_q;
	logic [STEP_W-1:0]  step_q;
	logic [SPEED_W-1:0] rem_q;
	logic [SPEED_W-1:0] work_q;
	logic [SPEED_W:0]   trial;
	logic               qbit;
	logic [SPEED_W-1:0] rem_nxt;
	logic [SPEED_W-1:0] work_nxt;
	logic [SPEED_W-1:0] wr_val;
	logic               wr;

	assign cfg.ready  = !busy_q;
	assign wr         = cfg.valid && !busy_q;
	// a zero limit acts as one
	assign wr_val     = (cfg.max_speed == '0) ? SPEED_W'(1) : cfg.max_speed;
	assign max_speed  = max_q;
	assign duty_scale = scale_q;
	assign busy       = busy_q;

	// one restoring divide step per cycle, divisor is the stored limit
	always_comb begin
		trial    = {rem_q, work_q[SPEED_W-1]};
		qbit     = (trial >= {1'b0, max_q});
		if (qbit) begin
			trial = trial - {1'b0, max_q};
		end
		rem_nxt  = trial[SPEED_W-1:0];
		work_nxt = {work_q[SPEED_W-2:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= MAX_SPEED_RESET;
			scale_q <= SCALE_RESET;
			busy_q  <= 1'b0;
			step_q  <= '0;
		end else if (wr) begin
			max_q  <= wr_val;
			busy_q <= 1'b1;
			step_q <= STEP_W'(SPEED_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				scale_q <= work_nxt;
				busy_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			rem_q  <= '0;
			work_q <= DUTY_FULL;
		end else if (busy_q) begin
			rem_q  <= rem_nxt;
			work_q <= work_nxt;
		end
	end

endmodule

// ===== hdl/esd_front.sv =====
// Front end: accepts command items and classifies them into back-end operations.
`timescale 1ns / 1ps
module esd_front (
	esd_cmd_if.sink          cmd,
	input  logic             scale_busy,
	input  logic             q_full,
	output logic             push,
	output esd_pkg::esd_op_t push_op
);
	import esd_pkg::*;

	// hold off while the queue is full or the scale is being recomputed
	assign cmd.ready = !q_full && !scale_busy;
	assign push      = cmd.valid && cmd.ready;

	always_comb begin
		push_op.speed = cmd.speed_cmd;
		push_op.dir   = cmd.dir_cmd;
		unique case (cmd.action)
			ACT_EDGE:  push_op.op = cmd.enc_b_level ? OP_CNT_DN : OP_CNT_UP;
			ACT_TICK:  push_op.op = OP_TICK;
			ACT_SPEED: push_op.op = OP_SPEED;
			ACT_DIR:   push_op.op = OP_DIR;
			ACT_STOP:  push_op.op = OP_STOP;
			default:   push_op.op = OP_NOP;
		endcase
	end

endmodule

// ===== hdl/esd_queue.sv =====
// Short FIFO of classified operations between the front and the back.
`timescale 1ns / 1ps
module esd_queue #(
	parameter int DEPTH = esd_pkg::QUEUE_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  esd_pkg::esd_op_t push_op,
	output logic             full,
	input  logic             pop,
	output esd_pkg::esd_op_t pop_op,
	output logic             empty
);
	import esd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_Q_W = $clog2(DEPTH + 1);

	esd_op_t             mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_Q_W-1:0]  fill_q;

	assign full   = (fill_q == CNT_Q_W'(DEPTH));
	assign empty  = (fill_q == '0);
	assign pop_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_Q_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_Q_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// ===== hdl/esd_back.sv =====
// Back end: drive state update, window divide pipeline and status output register.
`timescale 1ns / 1ps
module esd_back #(
	parameter int PULSES_PER_REV = esd_pkg::PPR_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  esd_pkg::esd_op_t            q_op,
	output logic                        pop,
	input  logic [esd_pkg::SPEED_W-1:0] max_speed,
	input  logic [esd_pkg::SPEED_W-1:0] duty_scale,
	esd_status_if.source                status
);
	import esd_pkg::*;

	localparam int DIV_W = $clog2(PULSES_PER_REV + 1);
	localparam logic [DIV_W:0] DIVISOR = (DIV_W + 1)'(PULSES_PER_REV);
	localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W - 1){1'b1}}};
	localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W - 1){1'b0}}};

	typedef struct packed {
		logic [1:0]         pins;
		logic [SPEED_W-1:0] duty;
		logic [SPEED_W-1:0] target;
		logic               tick;
		logic               neg;
	} esd_snap_t;

	// resolve DIV_STEPS quotient bits of |count| / PULSES_PER_REV
	function automatic logic [DIV_W+CNT_W-1:0] div_steps(
		input logic [DIV_W-1:0] rem_in,
		input logic [CNT_W-1:0] work_in
	);
		logic [DIV_W-1:0] rem;
		logic [CNT_W-1:0] work;
		logic [DIV_W:0]   trial;
		rem  = rem_in;
		work = work_in;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {rem, work[CNT_W-1]};
			if (trial >= DIVISOR) begin
				trial = trial - DIVISOR;
				work  = {work[CNT_W-2:0], 1'b1};
			end else begin
				work  = {work[CNT_W-2:0], 1'b0};
			end
			rem = trial[DIV_W-1:0];
		end
		return {rem, work};
	endfunction

	// architectural state
	logic signed [CNT_W-1:0] count_q;
	logic [SPEED_W-1:0]      cmd_q;
	logic [SPEED_W-1:0]      duty_q;
	logic                    dir_q;
	logic [1:0]              pins_q;
	logic signed [CNT_W-1:0] reading_q;

	logic signed [CNT_W-1:0] count_nxt;
	logic [SPEED_W-1:0]      cmd_nxt;
	logic [SPEED_W-1:0]      duty_nxt;
	logic                    dir_nxt;
	logic [1:0]              pins_nxt;
	logic [SPEED_W-1:0]      lim;
	logic [2*SPEED_W-1:0]    prod;
	logic [CNT_W-1:0]        mag;
	esd_snap_t               snap_nxt;

	// pipeline: index 0 is the execute stage, index k the k-th divide stage
	logic [DIV_STAGES:0]     valid_s;
	esd_snap_t               snap_s [DIV_STAGES+1];
	logic [DIV_W-1:0]        rem_s  [DIV_STAGES+1];
	logic [CNT_W-1:0]        work_s [DIV_STAGES+1];

	logic                    adv;
	logic                    out_valid_q;
	esd_snap_t               tail;
	logic [CNT_W-1:0]        quot;
	logic signed [CNT_W-1:0] measured;
	logic signed [CNT_W-1:0] measured_q;
	esd_snap_t               out_q;

	// the whole pipe moves when the output register is free or being emptied
	assign adv = !out_valid_q || status.ready;
	assign pop = adv && !q_empty;

	always_comb begin
		count_nxt = count_q;
		cmd_nxt   = cmd_q;
		duty_nxt  = duty_q;
		dir_nxt   = dir_q;
		pins_nxt  = pins_q;
		lim       = (q_op.speed > max_speed) ? max_speed : q_op.speed;
		prod      = lim * duty_scale;
		mag       = count_q[CNT_W-1] ? (~count_q + CNT_W'(1)) : count_q;
		unique case (q_op.op)
			OP_CNT_UP: begin
				if (count_q != CNT_MAX) begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_CNT_DN: begin
				if (count_q != CNT_MIN) begin
					count_nxt = count_q - CNT_W'(1);
				end
			end
			OP_TICK: count_nxt = '0;
			OP_SPEED: begin
				if (q_op.speed != cmd_q && lim != cmd_q) begin
					cmd_nxt  = lim;
					duty_nxt = prod[SPEED_W-1:0];
				end
			end
			OP_DIR: begin
				if (q_op.dir != dir_q) begin
					dir_nxt  = q_op.dir;
					pins_nxt = q_op.dir ? PINS_CW : PINS_CCW;
				end
			end
			OP_STOP: begin
				cmd_nxt  = '0;
				duty_nxt = '0;
				pins_nxt = PINS_OFF;
			end
			default: ;
		endcase
		snap_nxt.pins   = pins_nxt;
		snap_nxt.duty   = duty_nxt;
		snap_nxt.target = cmd_nxt;
		snap_nxt.tick   = (q_op.op == OP_TICK);
		snap_nxt.neg    = count_q[CNT_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cmd_q   <= '0;
			duty_q  <= '0;
			dir_q   <= 1'b0;
			pins_q  <= PINS_OFF;
		end else if (pop) begin
			count_q <= count_nxt;
			cmd_q   <= cmd_nxt;
			duty_q  <= duty_nxt;
			dir_q   <= dir_nxt;
			pins_q  <= pins_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[DIV_STAGES-1:0], pop};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			snap_s[0] <= snap_nxt;
			rem_s[0]  <= '0;
			work_s[0] <= mag;
			for (int k = 1; k <= DIV_STAGES; k++) begin
				snap_s[k]             <= snap_s[k-1];
				{rem_s[k], work_s[k]} <= div_steps(rem_s[k-1], work_s[k-1]);
			end
		end
	end

	// tail: apply the sign to the quotient, or report the held reading
	assign tail     = snap_s[DIV_STAGES];
	assign quot     = work_s[DIV_STAGES];
	assign measured = !tail.tick ? reading_q :
		(tail.neg ? -$signed(quot) : $signed(quot));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			reading_q   <= '0;
		end else if (adv) begin
			out_valid_q <= valid_s[DIV_STAGES];
			if (valid_s[DIV_STAGES] && tail.tick) begin
				reading_q <= measured;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s[DIV_STAGES]) begin
			out_q      <= tail;
			measured_q <= measured;
		end
	end

	assign status.valid          = out_valid_q;
	assign status.bridge_a       = out_q.pins[0];
	assign status.bridge_b       = out_q.pins[1];
	assign status.pwm_level      = out_q.duty;
	assign status.measured_speed = measured_q;
	assign status.target_speed   = out_q.target;

endmodule

// ===== hdl/encoder_speed_and_pwm_motor_drive.sv =====
// Top level of the single-motor encoder speed and PWM H-bridge drive.
`timescale 1ns / 1ps
//  channel  | direction | payload                                         | handshake
//  ---------+-----------+-------------------------------------------------+-------------
//  cmd      | in        | action, enc_b_level, speed_cmd, dir_cmd         | valid/ready
//  status   | out       | bridge_a, bridge_b, pwm_level, measured_speed,  | valid/ready
//           |           | target_speed                                    |
//  cfg      | in        | max_speed                                       | valid/ready
//
//  Sustained rate is one item per clock while status.ready stays high and no max_speed
//  write is in progress; every item yields one status item. From the cmd accept edge
//  an item passes the queue, the execute stage, eight divide stages of four quotient
//  bits each, and the output register. The divide stages are what set the latency.
//  A max_speed write holds cmd.ready low until the scale divider is done: it resolves
//  one bit per cycle. Reset clears all drive state at once; no clearing pass. A stalled
//  status item holds the pipe; the four-entry queue keeps taking items until it fills.
module encoder_speed_and_pwm_motor_drive #(
	parameter int PULSES_PER_REV = esd_pkg::PPR_DEFAULT,
	parameter int QUEUE_DEPTH    = esd_pkg::QUEUE_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	esd_cmd_if.sink      cmd,
	esd_status_if.source status,
	esd_cfg_if.sink      cfg
);
	import esd_pkg::*;

	logic               scale_busy;
	logic [SPEED_W-1:0] max_speed;
	logic [SPEED_W-1:0] duty_scale;
	logic               push;
	esd_op_t            push_op;
	logic               q_full;
	logic               q_empty;
	logic               pop;
	esd_op_t            pop_op;

	// limit register and the scale it implies
	esd_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.max_speed  (max_speed),
		.duty_scale (duty_scale),
		.busy       (scale_busy)
	);

	// classify incoming items; stall while the scale is recomputed
	esd_front u_front (
		.cmd        (cmd),
		.scale_busy (scale_busy),
		.q_full     (q_full),
		.push       (push),
		.push_op    (push_op)
	);

	// decouple the accept side from the execute side
	esd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.pop_op  (pop_op),
		.empty   (q_empty)
	);

	// execute, divide the window count, and present the status item
	esd_back #(
		.PULSES_PER_REV (PULSES_PER_REV)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_op       (pop_op),
		.pop        (pop),
		.max_speed  (max_speed),
		.duty_scale (duty_scale),
		.status     (status)
	);

endmodule

// ===== tb/motor_drive_checker.sv =====
// Checker that predicts each status item of the motor drive and compares it with the block.
`timescale 1ns / 1ps
module motor_drive_checker #(
	parameter int PULSES_PER_REV = esd_pkg::PPR_DEFAULT
) (
	input  logic  clk,
	input  logic  arst_n,
	esd_cmd_if    cmd,
	esd_status_if status,
	esd_cfg_if    cfg,
	output int    pending,
	output int    fails
);
	import esd_pkg::*;

	localparam logic signed [CNT_W-1:0] COUNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
	localparam logic signed [CNT_W-1:0] COUNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};

	typedef struct packed {
		logic                    bridge_a;
		logic                    bridge_b;
		logic [SPEED_W-1:0]      pwm;
		logic signed [CNT_W-1:0] meas;
		logic [SPEED_W-1:0]      target;
	} drive_status_t;

	logic signed [CNT_W-1:0] pulse_cnt;
	logic signed [CNT_W-1:0] speed_rd;
	logic [SPEED_W-1:0]      target_spd;
	logic [SPEED_W-1:0]      duty;
	logic [SPEED_W-1:0]      speed_limit;
	logic [SPEED_W-1:0]      duty_scale;
	logic                    dir_st;
	logic [1:0]              pins;
	drive_status_t           status_q[$];
	int                      mismatch_cnt;

	task automatic check_field(input string what, input logic [CNT_W-1:0] want,
		input logic [CNT_W-1:0] got);
		if (want !== got) begin
			mismatch_cnt++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		drive_status_t      want;
		logic [SPEED_W-1:0] clamped;
		logic [SPEED_W-1:0] wr;
		if (!arst_n) begin
			pulse_cnt   = '0;
			speed_rd    = '0;
			target_spd  = '0;
			duty        = '0;
			speed_limit = MAX_SPEED_RESET;
			duty_scale  = SCALE_RESET;
			dir_st      = 1'b0;
			pins        = PINS_OFF;
			status_q.delete();
			mismatch_cnt = 0;
			pending <= 0;
			fails   <= 0;
		end else begin
			// Compare the outgoing item first; nothing accepted this edge can be in it.
			if (status.valid && status.ready) begin
				if (status_q.size() == 0) begin
					mismatch_cnt++;
					$display("%0t: status item with none pending, expected none, actual pwm %h target %h",
						$time, status.pwm_level, status.target_speed);
				end else begin
					want = status_q.pop_front();
					check_field("bridge_a", CNT_W'(want.bridge_a), CNT_W'(status.bridge_a));
					check_field("bridge_b", CNT_W'(want.bridge_b), CNT_W'(status.bridge_b));
					check_field("pwm_level", CNT_W'(want.pwm), CNT_W'(status.pwm_level));
					check_field("measured_speed", want.meas, status.measured_speed);
					check_field("target_speed", CNT_W'(want.target), CNT_W'(status.target_speed));
				end
			end

			if (cfg.valid && cfg.ready) begin
				wr = (cfg.max_speed == '0) ? SPEED_W'(1) : cfg.max_speed;
				speed_limit = wr;
				duty_scale  = DUTY_FULL / wr;
			end

			if (cmd.valid && cmd.ready) begin
				case (cmd.action)
					ACT_EDGE: begin
						if (cmd.enc_b_level) begin
							if (pulse_cnt != COUNT_MIN)
								pulse_cnt = pulse_cnt - 1;
						end else if (pulse_cnt != COUNT_MAX) begin
							pulse_cnt = pulse_cnt + 1;
						end
					end
					ACT_TICK: begin
						speed_rd  = pulse_cnt / PULSES_PER_REV;
						pulse_cnt = '0;
					end
					ACT_SPEED: begin
						if (cmd.speed_cmd != target_spd) begin
							clamped = (cmd.speed_cmd > speed_limit) ? speed_limit : cmd.speed_cmd;
							if (clamped != target_spd) begin
								target_spd = clamped;
								duty       = clamped * duty_scale;
							end
						end
					end
					ACT_DIR: begin
						if (cmd.dir_cmd != dir_st) begin
							dir_st = cmd.dir_cmd;
							pins   = cmd.dir_cmd ? PINS_CW : PINS_CCW;
						end
					end
					ACT_STOP: begin
						target_spd = '0;
						duty       = '0;
						pins       = PINS_OFF;
					end
					default: ;
				endcase
				want.bridge_a = pins[0];
				want.bridge_b = pins[1];
				want.pwm      = duty;
				want.meas     = speed_rd;
				want.target   = target_spd;
				status_q.push_back(want);
			end

			pending <= status_q.size();
			fails   <= mismatch_cnt;
		end
	end

endmodule

// ===== tb/encoder_speed_and_pwm_motor_drive_tb.sv =====
// Stimulus, reset, watchdog and verdict for the encoder speed and PWM motor drive.
`timescale 1ns / 1ps
module encoder_speed_and_pwm_motor_drive_tb;
	import esd_pkg::*;

	// First and last action codes that the block leaves unused
	localparam int ACT_SPARE_FIRST = 5;
	localparam int ACT_SPARE_LAST  = 7;
	// Cycles without any accepted item before the run is declared hung
	localparam int IDLE_LIMIT = 2000;
	// Pipe latency plus margin, waited out once the last status item is in
	localparam int DRAIN_TAIL = DIV_STAGES + 3 + 10;
	localparam int PHASES     = 7;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic quiet;
	int   pending;
	int   fails;
	int   idle_cycles = 0;
	int   sink_hold;
	int   cur_max;
	logic [SPEED_W-1:0] last_speed;
	logic [SPEED_W-1:0] phase_max [PHASES];

	esd_cmd_if    cmd_ch();
	esd_status_if status_ch();
	esd_cfg_if    cfg_ch();

	encoder_speed_and_pwm_motor_drive dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.status (status_ch),
		.cfg    (cfg_ch)
	);

	motor_drive_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.status  (status_ch),
		.cfg     (cfg_ch),
		.pending (pending),
		.fails   (fails)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length: mostly none or a few cycles, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Status sink: take items, drop ready for random stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_ch.ready <= 1'b0;
			sink_hold       <= 0;
		end else if (sink_hold != 0) begin
			status_ch.ready <= 1'b0;
			sink_hold       <= sink_hold - 1;
		end else begin
			status_ch.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				sink_hold <= pick_gap();
		end
	end

	// Watchdog: any accepted item on any channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (status_ch.valid && status_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[encoder_speed_and_pwm_motor_drive] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one command item after a random gap and hold it until accepted.
	// Valid stays high on return so back-to-back items need no extra edge.
	task automatic send_item(input logic [ACTION_W-1:0] act, input logic b_level,
		input logic [SPEED_W-1:0] spd, input logic dir);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.action      <= act;
		cmd_ch.enc_b_level <= b_level;
		cmd_ch.speed_cmd   <= spd;
		cmd_ch.dir_cmd     <= dir;
		do @(posedge clk); while (!cmd_ch.ready);
		if (act == ACT_SPEED)
			last_speed = spd;
	endtask

	// Drop valid and hold off until every status item has come back.
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Write max_speed with the block idle; the block runs its scale divide afterwards
	// with cmd.ready low, so the next item simply waits on ready.
	task automatic write_max_speed(input logic [SPEED_W-1:0] v);
		wait_drained();
		cfg_ch.valid     <= 1'b1;
		cfg_ch.max_speed <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_max = (v == '0) ? 1 : int'(v);
	endtask

	// Random traffic, mostly well-formed: encoder bursts closed by a window tick,
	// speed commands near the limit, direction flips and stops, plus some noise.
	task automatic run_phase(input int n_items);
		int sent;
		int r;
		int len;
		int pick;
		logic b_dom;
		logic [SPEED_W-1:0] spd;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				// Long bursts now and then, so readings leave zero in both signs
				len   = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(2, 30);
				b_dom = 1'($urandom_range(0, 1));
				repeat (len)
					send_item(ACT_EDGE, b_dom ^ ($urandom_range(0, 9) == 0),
						SPEED_W'($urandom), 1'($urandom));
				send_item(ACT_TICK, 1'($urandom), SPEED_W'($urandom), 1'($urandom));
				sent += len + 1;
			end else if (r < 72) begin
				pick = $urandom_range(0, 4);
				case (pick)
					0: spd = SPEED_W'($urandom);
					1: spd = SPEED_W'($urandom_range(0, cur_max));
					2: spd = SPEED_W'(cur_max);
					3: spd = SPEED_W'(cur_max + 1);
					default: spd = last_speed;
				endcase
				send_item(ACT_SPEED, 1'($urandom), spd, 1'($urandom));
				sent++;
			end else if (r < 84) begin
				send_item(ACT_DIR, 1'($urandom), SPEED_W'($urandom), 1'($urandom));
				sent++;
			end else if (r < 90) begin
				send_item(ACT_STOP, 1'($urandom), SPEED_W'($urandom), 1'($urandom));
				sent++;
			end else begin
				send_item(ACTION_W'($urandom_range(0, ACT_SPARE_LAST)), 1'($urandom),
					SPEED_W'($urandom), 1'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		// Drive every input to a known value before the first edge
		cmd_ch.valid       = 1'b0;
		cmd_ch.action      = ACT_EDGE;
		cmd_ch.enc_b_level = 1'b0;
		cmd_ch.speed_cmd   = '0;
		cmd_ch.dir_cmd     = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.max_speed   = '0;
		quiet      = 1'b0;
		cur_max    = int'(MAX_SPEED_RESET);
		last_speed = '0;

		phase_max[0] = 16'd1;
		phase_max[1] = 16'hFFFF;
		phase_max[2] = 16'd2;
		phase_max[3] = 16'd1000;
		phase_max[4] = SPEED_W'($urandom_range(3, 65534));
		phase_max[5] = SPEED_W'($urandom_range(2, 300));
		phase_max[6] = 16'hFFFF;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: stop from reset, direction changes and repeats, stop then the
		// same direction again (pins stay off), short encoder runs in both senses
		send_item(ACT_STOP, 1'b1, 16'hFFFF, 1'b1);
		send_item(ACT_DIR, 1'b0, 16'h0000, 1'b1);
		send_item(ACT_DIR, 1'b1, 16'hFFFF, 1'b1);
		send_item(ACT_DIR, 1'b0, 16'h0000, 1'b0);
		send_item(ACT_STOP, 1'b0, 16'h0000, 1'b0);
		send_item(ACT_DIR, 1'b0, 16'h0000, 1'b0);
		send_item(ACT_EDGE, 1'b0, 16'hFFFF, 1'b1);
		send_item(ACT_EDGE, 1'b1, 16'h0000, 1'b0);
		send_item(ACT_EDGE, 1'b1, 16'hFFFF, 1'b1);
		send_item(ACT_EDGE, 1'b1, 16'h0000, 1'b0);
		send_item(ACT_TICK, 1'b1, 16'hFFFF, 1'b1);
		// Speed extremes at the reset limit, and a repeated command
		send_item(ACT_SPEED, 1'b0, 16'hFFFF, 1'b0);
		send_item(ACT_SPEED, 1'b1, 16'hFFFF, 1'b1);
		send_item(ACT_SPEED, 1'b0, 16'h0000, 1'b0);
		send_item(ACT_SPEED, 1'b1, 16'h0001, 1'b1);
		// Unused action codes leave the state alone
		for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
			send_item(ACTION_W'(a), 1'b1, 16'hFFFF, 1'b1);

		// A zero write acts as a limit of one with full scale
		write_max_speed(16'h0000);
		send_item(ACT_SPEED, 1'b0, 16'h0002, 1'b0);
		send_item(ACT_SPEED, 1'b0, 16'h0001, 1'b0);
		send_item(ACT_SPEED, 1'b0, 16'h0000, 1'b0);

		// Lowering the limit keeps a higher commanded speed until a different one comes
		write_max_speed(16'hFFFF);
		send_item(ACT_SPEED, 1'b0, 16'd5000, 1'b0);
		write_max_speed(16'd1000);
		send_item(ACT_SPEED, 1'b0, 16'd5000, 1'b0);
		send_item(ACT_SPEED, 1'b0, 16'd6000, 1'b0);

		// Random phases, each under its own limit; one runs with no idling at all,
		// one pauses mid-phase until the pipe is empty
		for (int p = 0; p < PHASES; p++) begin
			write_max_speed(phase_max[p]);
			quiet = (p == 3);
			if (p == 2) begin
				run_phase(28);
				wait_drained();
				run_phase(28);
			end else begin
				run_phase(55);
			end
		end
		quiet = 1'b0;

		// Wait out every pending item, then the pipe latency, then give the verdict
		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (fails == 0)
			$display("[encoder_speed_and_pwm_motor_drive] OK");
		else
			$display("[encoder_speed_and_pwm_motor_drive] ERROR");
		$finish;
	end

endmodule
